>>> hw/rtl/ffea_pkg.sv
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared constants for the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam int unsigned MemTopDefault     = 1023;
  localparam int unsigned MaxExtentsDefault = 16;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

endpackage

>>> hw/rtl/first_fit_extent_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit allocator over an address-ordered table of free extents.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. After reset the block writes the
// initial extent 0..MEM_TOP in S_INIT before it raises in_ready_o. The table
// has a single registered read port, so each table entry visited takes a read
// state and a check state. Every transaction ends in S_PUSH, which loads the
// output register. An allocate that fails at once (zero size or empty table)
// goes straight to S_PUSH; otherwise it scans at most MAX_EXTENTS entries, and
// an exact fit then moves the later entries down. A free that fails at once
// goes straight to S_PUSH; otherwise it scans at most MAX_EXTENTS entries to
// find its place. An insert moves the later entries up, and a double merge
// moves the later entries down. A new transaction is taken while the previous
// result still waits on the output; its result then waits until the output
// register is free.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator #(
  parameter int unsigned MEM_TOP     = ffea_pkg::MemTopDefault,
  parameter int unsigned MAX_EXTENTS = ffea_pkg::MaxExtentsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [$clog2(MEM_TOP+1):0]       block_size_i,
  input  logic [$clog2(MEM_TOP+1)-1:0]     block_address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [$clog2(MEM_TOP+1)-1:0]     granted_address_o,
  output logic                             ok_o
);

  import ffea_pkg::*;

  localparam int unsigned AW = $clog2(MEM_TOP + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned EW = AW + 2;
  localparam int unsigned IW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned WW = 2 * AW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_F_DEC,
    S_DN_RD, S_DN_WR, S_UP_RD, S_UP_WR, S_F_INS, S_PUSH
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] sh_q, sh_d;
  logic [SW-1:0] size_q, size_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [EW-1:0] end_q, end_d;
  logic [AW-1:0] prv_start_q, prv_start_d, prv_last_q, prv_last_d;
  logic [AW-1:0] nxt_start_q, nxt_start_d, nxt_last_q, nxt_last_d;
  logic          res_ok_q, res_ok_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic          out_valid_q, out_valid_d;
  logic          out_ok_q, out_ok_d;
  logic [AW-1:0] out_addr_q, out_addr_d;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [AW-1:0] rd_start, rd_last;
  logic [SW-1:0] rd_len;
  logic [EW-1:0] in_end;
  logic          has_prev, has_next, join_prev, join_next;

  ffea_table #(
    .Depth (MAX_EXTENTS),
    .Width (WW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_start  = rdata[WW-1:AW];
  assign rd_last   = rdata[AW-1:0];
  assign rd_len    = SW'({1'b0, rd_last} - {1'b0, rd_start}) + SW'(1);
  assign in_end    = EW'(block_address_i) + EW'(block_size_i) - EW'(1);
  assign has_prev  = (idx_q != '0);
  assign has_next  = (idx_q < cnt_q);
  assign join_prev = has_prev && ((SW'(prv_last_q) + SW'(1)) == SW'(addr_q));
  assign join_next = has_next && ((end_q + EW'(1)) == EW'(nxt_start_q));

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign ok_o              = out_ok_q;
  assign granted_address_o = out_addr_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sh_d        = sh_q;
    size_d      = size_q;
    addr_d      = addr_q;
    end_d       = end_q;
    prv_start_d = prv_start_q;
    prv_last_d  = prv_last_q;
    nxt_start_d = nxt_start_q;
    nxt_last_d  = nxt_last_q;
    res_ok_d    = res_ok_q;
    res_addr_d  = res_addr_q;
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_addr_d  = out_addr_q;
    we          = 1'b0;
    waddr       = idx_q[IW-1:0];
    wdata       = rdata;
    re          = 1'b0;
    raddr       = idx_q[IW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {AW'(0), AW'(MEM_TOP)};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          size_d     = block_size_i;
          addr_d     = block_address_i;
          end_d      = in_end;
          idx_d      = '0;
          res_ok_d   = 1'b0;
          res_addr_d = '0;
          if (block_size_i == '0) begin
            state_d = S_PUSH;
          end else if (kind_i == KindAlloc) begin
            state_d = (cnt_q == '0) ? S_PUSH : S_A_RD;
          end else if (in_end > EW'(MEM_TOP)) begin
            state_d = S_PUSH;
          end else begin
            state_d = (cnt_q == '0) ? S_F_DEC : S_F_RD;
          end
        end
      end
      S_A_RD: begin
        re      = 1'b1;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (rd_len > size_q) begin
          we         = 1'b1;
          wdata      = {rd_start + size_q[AW-1:0], rd_last};
          res_ok_d   = 1'b1;
          res_addr_d = rd_start;
          state_d    = S_PUSH;
        end else if (rd_len == size_q) begin
          res_ok_d   = 1'b1;
          res_addr_d = rd_start;
          state_d    = S_DN_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ((idx_q + CW'(1)) == cnt_q) ? S_PUSH : S_A_RD;
        end
      end
      S_F_RD: begin
        re      = 1'b1;
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if (rd_start <= addr_q) begin
          prv_start_d = rd_start;
          prv_last_d  = rd_last;
          idx_d       = idx_q + CW'(1);
          state_d     = ((idx_q + CW'(1)) == cnt_q) ? S_F_DEC : S_F_RD;
        end else begin
          nxt_start_d = rd_start;
          nxt_last_d  = rd_last;
          state_d     = S_F_DEC;
        end
      end
      S_F_DEC: begin
        state_d = S_PUSH;
        if (has_prev && (prv_last_q >= addr_q)) begin
          res_ok_d = 1'b0;
        end else if (has_next && (EW'(nxt_start_q) <= end_q)) begin
          res_ok_d = 1'b0;
        end else if (join_prev && join_next) begin
          we       = 1'b1;
          waddr    = IW'(idx_q - CW'(1));
          wdata    = {prv_start_q, nxt_last_q};
          res_ok_d = 1'b1;
          state_d  = S_DN_RD;
        end else if (join_prev) begin
          we       = 1'b1;
          waddr    = IW'(idx_q - CW'(1));
          wdata    = {prv_start_q, end_q[AW-1:0]};
          res_ok_d = 1'b1;
        end else if (join_next) begin
          we       = 1'b1;
          wdata    = {addr_q, nxt_last_q};
          res_ok_d = 1'b1;
        end else if (cnt_q >= CW'(MAX_EXTENTS)) begin
          res_ok_d = 1'b0;
        end else begin
          sh_d    = cnt_q;
          state_d = S_UP_RD;
        end
      end
      S_DN_RD: begin
        if ((idx_q + CW'(1)) < cnt_q) begin
          re      = 1'b1;
          raddr   = IW'(idx_q + CW'(1));
          state_d = S_DN_WR;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_PUSH;
        end
      end
      S_DN_WR: begin
        we      = 1'b1;
        idx_d   = idx_q + CW'(1);
        state_d = S_DN_RD;
      end
      S_UP_RD: begin
        if (sh_q > idx_q) begin
          re      = 1'b1;
          raddr   = IW'(sh_q - CW'(1));
          state_d = S_UP_WR;
        end else begin
          state_d = S_F_INS;
        end
      end
      S_UP_WR: begin
        we      = 1'b1;
        waddr   = sh_q[IW-1:0];
        sh_d    = sh_q - CW'(1);
        state_d = S_UP_RD;
      end
      S_F_INS: begin
        we       = 1'b1;
        wdata    = {addr_q, end_q[AW-1:0]};
        cnt_d    = cnt_q + CW'(1);
        res_ok_d = 1'b1;
        state_d  = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_addr_d  = res_addr_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    sh_q        <= sh_d;
    size_q      <= size_d;
    addr_q      <= addr_d;
    end_q       <= end_d;
    prv_start_q <= prv_start_d;
    prv_last_q  <= prv_last_d;
    nxt_start_q <= nxt_start_d;
    nxt_last_q  <= nxt_last_d;
    res_ok_q    <= res_ok_d;
    res_addr_q  <= res_addr_d;
    out_ok_q    <= out_ok_d;
    out_addr_q  <= out_addr_d;
  end

endmodule

>>> hw/rtl/ffea_table.sv
// ----------------------------------------------------------------------------
// ffea_table
// Extent table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffea_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
